// ===== src/elmc_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder lane motor controller package
// Shared types, codes and reset constants for the lane controller.
// ----------------------------------------------------------------------------
package elmc_pkg;

  // Default encoder count width.
  localparam int unsigned CountWidthDef = 10;

  // Stall and ignore timers are fixed at eight bits.
  localparam int unsigned TimerWidth = 8;

  // Speed is a pulse period in control ticks.
  localparam int unsigned SpeedWidth = 3;

  // Register index width of the configuration port.
  localparam int unsigned CfgIndexWidth = 3;

  // Reset values of the configuration registers.
  localparam int unsigned RstUsableLength = 670;
  localparam int unsigned RstLimitLength  = 715;
  localparam logic [TimerWidth-1:0] RstStallIgnore = 8'd10;
  localparam logic [TimerWidth-1:0] RstStallPeriod = 8'd12;
  localparam int unsigned RstFarDistance  = 50;
  localparam int unsigned RstNearDistance = 25;

  // Speeds chosen in seek mode, and the speed after reset.
  localparam logic [SpeedWidth-1:0] SpeedFast  = 3'd1;
  localparam logic [SpeedWidth-1:0] SpeedMid   = 3'd3;
  localparam logic [SpeedWidth-1:0] SpeedSlow  = 3'd5;
  localparam logic [SpeedWidth-1:0] SpeedReset = 3'd3;

  // Pulse timer values used when the seek speed changes; PulseOne also on clear and reset.
  localparam logic [SpeedWidth-1:0] PulseOne = 3'd1;
  localparam logic [SpeedWidth-1:0] PulseTwo = 3'd2;

  typedef enum logic [1:0] {
    CMD_ENCODER = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_START   = 2'd2,
    CMD_TARGET  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_STOP   = 2'd0,
    MODE_RETURN = 2'd1,
    MODE_SEEK   = 2'd2,
    MODE_CAL    = 2'd3
  } mode_e;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_USABLE_LENGTH = 3'd0,
    CFG_LIMIT_LENGTH  = 3'd1,
    CFG_STALL_IGNORE  = 3'd2,
    CFG_STALL_PERIOD  = 3'd3,
    CFG_FAR_DISTANCE  = 3'd4,
    CFG_NEAR_DISTANCE = 3'd5
  } cfg_index_e;

endpackage

// ===== src/elmc_if.sv =====
// ----------------------------------------------------------------------------
// Encoder lane motor controller channels
// Valid/ready channels for command words, result words and register writes.
// ----------------------------------------------------------------------------

// Command word channel.
interface elmc_in_if #(
  parameter int unsigned COUNT_WIDTH = elmc_pkg::CountWidthDef
);
  logic                            valid;
  logic                            ready;
  logic [1:0]                      cmd;
  logic                            encoder_level;
  logic                            start_switch_level;
  logic [1:0]                      new_mode;
  logic [elmc_pkg::SpeedWidth-1:0] speed_set;
  logic                            clear_track;
  logic [COUNT_WIDTH-1:0]          target_count;

  modport source (
    output valid, cmd, encoder_level, start_switch_level, new_mode, speed_set,
           clear_track, target_count,
    input  ready
  );
  modport sink (
    input  valid, cmd, encoder_level, start_switch_level, new_mode, speed_set,
           clear_track, target_count,
    output ready
  );
endinterface

// Result word channel.
interface elmc_out_if #(
  parameter int unsigned COUNT_WIDTH = elmc_pkg::CountWidthDef
);
  logic                   valid;
  logic                   ready;
  logic                   motor_on;
  logic [1:0]             lane_mode;
  logic [COUNT_WIDTH-1:0] position_count;
  logic                   end_reached;
  logic                   stall_seen;

  modport source (
    output valid, motor_on, lane_mode, position_count, end_reached, stall_seen,
    input  ready
  );
  modport sink (
    input  valid, motor_on, lane_mode, position_count, end_reached, stall_seen,
    output ready
  );
endinterface

// Register write channel.
interface elmc_cfg_if #(
  parameter int unsigned COUNT_WIDTH = elmc_pkg::CountWidthDef
);
  logic                               valid;
  logic                               ready;
  logic [elmc_pkg::CfgIndexWidth-1:0] index;
  logic [COUNT_WIDTH-1:0]             data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== src/encoder_lane_motor_controller.sv =====
// ----------------------------------------------------------------------------
// Encoder lane motor controller
// Counts encoder edges and drives one lane motor on control ticks.
// ----------------------------------------------------------------------------
// The block takes one command word per cycle unless the output stalls, and
// returns one result word for each: a word is first captured in an input
// register, then a single pass of comparisons and counter updates writes the
// lane state, and the state registers themselves form the result register.
// The input side stays ready while the result register is empty or its word
// is being taken in the same cycle, so ready on the input follows ready on the
// output combinationally. Register writes are taken at any time with ready
// held high, and are meant to be made only while the block is idle.
module encoder_lane_motor_controller #(
  parameter int unsigned COUNT_WIDTH = elmc_pkg::CountWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  elmc_in_if.sink     in_i,
  elmc_out_if.source  out_o,
  elmc_cfg_if.sink    cfg_i
);

  localparam int unsigned TW = elmc_pkg::TimerWidth;
  localparam int unsigned SW = elmc_pkg::SpeedWidth;
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  // Configuration registers.
  logic [COUNT_WIDTH-1:0] usable_length_q, limit_length_q;
  logic [COUNT_WIDTH-1:0] far_distance_q, near_distance_q;
  logic [TW-1:0]          stall_ignore_q, stall_period_q;

  // Input register.
  logic                   in_valid_q;
  elmc_pkg::cmd_e         cmd_q;
  logic                   enc_level_q;
  logic                   switch_level_q;
  elmc_pkg::mode_e        new_mode_q;
  logic [SW-1:0]          speed_set_q;
  logic                   clear_track_q;
  logic [COUNT_WIDTH-1:0] target_in_q;

  // Lane state, which also serves as the result register.
  logic                   out_valid_q;
  elmc_pkg::mode_e        mode_q, mode_d;
  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic [COUNT_WIDTH-1:0] target_q, target_d;
  logic [SW-1:0]          speed_q, speed_d;
  logic [SW-1:0]          pulse_q, pulse_d;
  logic [TW-1:0]          stall_timer_q, stall_timer_d;
  logic [TW-1:0]          ignore_timer_q, ignore_timer_d;
  logic                   last_level_q, last_level_d;
  logic                   seen_q, seen_d;
  logic                   end_q, end_d;
  logic                   stalled_q, stalled_d;
  logic                   motor_q, motor_d;

  logic advance;
  logic in_ready;

  // Handshake: a word moves into the state when the result slot is free.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  // Register writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      usable_length_q <= COUNT_WIDTH'(elmc_pkg::RstUsableLength);
      limit_length_q  <= COUNT_WIDTH'(elmc_pkg::RstLimitLength);
      stall_ignore_q  <= elmc_pkg::RstStallIgnore;
      stall_period_q  <= elmc_pkg::RstStallPeriod;
      far_distance_q  <= COUNT_WIDTH'(elmc_pkg::RstFarDistance);
      near_distance_q <= COUNT_WIDTH'(elmc_pkg::RstNearDistance);
    end else if (cfg_i.valid) begin
      case (elmc_pkg::cfg_index_e'(cfg_i.index))
        elmc_pkg::CFG_USABLE_LENGTH: usable_length_q <= cfg_i.data;
        elmc_pkg::CFG_LIMIT_LENGTH:  limit_length_q  <= cfg_i.data;
        elmc_pkg::CFG_STALL_IGNORE:  stall_ignore_q  <= cfg_i.data[TW-1:0];
        elmc_pkg::CFG_STALL_PERIOD:  stall_period_q  <= cfg_i.data[TW-1:0];
        elmc_pkg::CFG_FAR_DISTANCE:  far_distance_q  <= cfg_i.data;
        elmc_pkg::CFG_NEAR_DISTANCE: near_distance_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      cmd_q          <= elmc_pkg::cmd_e'(in_i.cmd);
      enc_level_q    <= in_i.encoder_level;
      switch_level_q <= in_i.start_switch_level;
      new_mode_q     <= elmc_pkg::mode_e'(in_i.new_mode);
      speed_set_q    <= in_i.speed_set;
      clear_track_q  <= in_i.clear_track;
      target_in_q    <= in_i.target_count;
    end
  end

  // Single pass over the lane state for the word in the input register.
  always_comb begin
    elmc_pkg::mode_e        mode_v;
    logic [TW-1:0]          stall_v;
    logic [COUNT_WIDTH-1:0] dist_v;
    logic [SW-1:0]          want_v;
    logic [SW-1:0]          speed_v;
    logic [SW-1:0]          pulse_v;

    mode_v  = mode_q;
    stall_v = stall_timer_q - 1'b1;
    dist_v  = (target_q > count_q) ? (target_q - count_q) : '0;
    want_v  = (dist_v > far_distance_q)  ? elmc_pkg::SpeedFast :
              (dist_v > near_distance_q) ? elmc_pkg::SpeedMid : elmc_pkg::SpeedSlow;
    speed_v = speed_q;
    pulse_v = pulse_q;

    mode_d         = mode_q;
    count_d        = count_q;
    target_d       = target_q;
    speed_d        = speed_q;
    pulse_d        = pulse_q;
    stall_timer_d  = stall_timer_q;
    ignore_timer_d = ignore_timer_q;
    last_level_d   = last_level_q;
    seen_d         = seen_q;
    end_d          = end_q;
    stalled_d      = stalled_q;
    motor_d        = motor_q;

    case (cmd_q)
      elmc_pkg::CMD_ENCODER: begin
        // Every level change counts, saturating at the top of the range.
        if (enc_level_q != last_level_q) begin
          if (count_q != CountMax) begin
            count_d = count_q + 1'b1;
          end
          seen_d = 1'b1;
        end
        last_level_d = enc_level_q;
      end

      elmc_pkg::CMD_TICK: begin
        // Mode-specific stops: start switch on return, target reached on seek.
        if (mode_v == elmc_pkg::MODE_RETURN && switch_level_q) begin
          mode_v = elmc_pkg::MODE_STOP;
        end else if (mode_v == elmc_pkg::MODE_SEEK && count_q >= target_q) begin
          mode_v = elmc_pkg::MODE_STOP;
        end

        // Track end, hard limit and stall window checks.
        if (mode_v != elmc_pkg::MODE_STOP) begin
          if ((mode_v == elmc_pkg::MODE_SEEK || mode_v == elmc_pkg::MODE_CAL) &&
              count_q > usable_length_q) begin
            mode_v = elmc_pkg::MODE_STOP;
            end_d  = 1'b1;
          end else if (count_q > limit_length_q) begin
            mode_v = elmc_pkg::MODE_STOP;
          end else if (ignore_timer_q != '0) begin
            ignore_timer_d = ignore_timer_q - 1'b1;
          end else if (stall_v != '0) begin
            stall_timer_d = stall_v;
          end else begin
            stall_timer_d = stall_period_q;
            if (!seen_q) begin
              mode_v    = elmc_pkg::MODE_STOP;
              stalled_d = 1'b1;
            end else begin
              seen_d = 1'b0;
            end
          end
        end
        mode_d = mode_v;

        // Motor pulse: seek adapts the speed to the remaining distance.
        if (mode_v == elmc_pkg::MODE_STOP) begin
          motor_d = 1'b0;
        end else begin
          if (mode_v == elmc_pkg::MODE_SEEK) begin
            if (want_v < speed_q) begin
              pulse_v = elmc_pkg::PulseOne;
              speed_v = want_v;
            end else if (want_v > speed_q) begin
              pulse_v = elmc_pkg::PulseTwo;
              speed_v = want_v;
            end
          end
          pulse_v = pulse_v - 1'b1;
          speed_d = speed_v;
          if (pulse_v == '0) begin
            pulse_d = speed_v;
            motor_d = !stalled_q;
          end else begin
            pulse_d = pulse_v;
            motor_d = 1'b0;
          end
        end
      end

      elmc_pkg::CMD_START: begin
        // Optional track clear, then the new speed, then the new mode.
        if (clear_track_q) begin
          seen_d        = 1'b0;
          end_d         = 1'b0;
          stalled_d     = 1'b0;
          stall_timer_d = stall_period_q;
          count_d       = '0;
          target_d      = '0;
          pulse_d       = elmc_pkg::PulseOne;
          last_level_d  = enc_level_q;
        end
        if (speed_set_q != '0) begin
          speed_d        = speed_set_q;
          pulse_d        = speed_set_q;
          stall_timer_d  = stall_period_q;
          ignore_timer_d = stall_ignore_q;
        end
        mode_d = new_mode_q;
      end

      elmc_pkg::CMD_TARGET: begin
        target_d = target_in_q;
      end

      default: ;
    endcase
  end

  // Lane state and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      mode_q         <= elmc_pkg::MODE_STOP;
      count_q        <= '0;
      target_q       <= '0;
      speed_q        <= elmc_pkg::SpeedReset;
      pulse_q        <= elmc_pkg::PulseOne;
      stall_timer_q  <= elmc_pkg::RstStallPeriod;
      ignore_timer_q <= elmc_pkg::RstStallIgnore;
      last_level_q   <= 1'b0;
      seen_q         <= 1'b0;
      end_q          <= 1'b0;
      stalled_q      <= 1'b0;
      motor_q        <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_q    <= 1'b1;
        mode_q         <= mode_d;
        count_q        <= count_d;
        target_q       <= target_d;
        speed_q        <= speed_d;
        pulse_q        <= pulse_d;
        stall_timer_q  <= stall_timer_d;
        ignore_timer_q <= ignore_timer_d;
        last_level_q   <= last_level_d;
        seen_q         <= seen_d;
        end_q          <= end_d;
        stalled_q      <= stalled_d;
        motor_q        <= motor_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result word straight from the lane state.
  assign out_o.valid          = out_valid_q;
  assign out_o.motor_on       = motor_q;
  assign out_o.lane_mode      = mode_q;
  assign out_o.position_count = count_q;
  assign out_o.end_reached    = end_q;
  assign out_o.stall_seen     = stalled_q;

  // An empty input register always takes a new word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_i.ready)
    else $error("input register empty but not ready");

  // Latching a stall or the track end always stops the lane.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(stalled_q) || $rose(end_q)) |-> (mode_q == elmc_pkg::MODE_STOP))
    else $error("stall or end latched without stopping the lane");

  // A stalled lane never has its motor driven.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stalled_q |-> !motor_q)
    else $error("motor driven while stalled");

endmodule
